>>> hdl/rlepsd_pkg.sv
// Shared types, codes and header constants of the run-length pixel stream decoder.
package rlepsd_pkg;

  localparam int unsigned HdrLen = 14;
  localparam int unsigned PixPerResult = 4;
  localparam int unsigned RunBias = 3;

  localparam logic [7:0] CmdSingleMask = 8'h80;
  localparam logic [7:0] AlphaMask = 8'h40;
  localparam logic [7:0] ColourMask = 8'h3F;
  localparam logic [7:0] AlphaFill = 8'hC0;
  localparam logic [7:0] RunLenMask = 8'h7F;

  typedef enum logic [1:0] {
    KIND_PIXELS  = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_BAD = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] original_size;
    logic [7:0]  pixel_one;
    logic [7:0]  pixel_two;
    logic [7:0]  pixel_three;
    logic [7:0]  pixel_four;
    logic [2:0]  pixel_count;
    logic        run_end;
    logic        stream_end;
  } out_item_t;

  // One classified command passed from the front end to the expander.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] size;
    logic [7:0]  pix;
    logic [7:0]  count;
    logic        stream_end;
  } cmd_t;

  function automatic logic is_magic_pos(logic [3:0] pos);
    return (pos < 4'd4) || ((pos >= 4'd8) && (pos < 4'd12));
  endfunction

  function automatic logic [7:0] magic_byte(logic [3:0] pos);
    logic [7:0] res;
    unique case (pos)
      4'd0:    res = 8'h43; // C
      4'd1:    res = 8'h6D; // m
      4'd2:    res = 8'h70; // p
      4'd3:    res = 8'h72; // r
      4'd8:    res = 8'h52; // R
      4'd9:    res = 8'h4C; // L
      4'd10:   res = 8'h45; // E
      4'd11:   res = 8'h32; // 2
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/rlepsd_front.sv
// Front end: header check and byte classification into decoder commands.
module rlepsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rlepsd_pkg::in_item_t in_data_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output rlepsd_pkg::cmd_t     push_data_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_IGNORE,
    PH_LITERAL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic        mismatch_q, mismatch_d;
  logic [31:0] size_q, size_d;
  logic [6:0]  run_len_q, run_len_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [3:0]  p;
  logic        mm;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign b          = in_data_i.data_byte;
  assign last       = in_data_i.last_byte;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    mismatch_d   = mismatch_q;
    size_d       = size_q;
    run_len_d    = run_len_q;
    push_valid_o = 1'b0;
    push_data_o  = '{kind: rlepsd_pkg::KIND_PIXELS, size: '0, pix: '0, count: '0,
                     stream_end: last};
    p  = (pos_q >= 4'(rlepsd_pkg::HdrLen - 1)) ? 4'(rlepsd_pkg::HdrLen - 1) : pos_q;
    mm = mismatch_q;

    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (rlepsd_pkg::is_magic_pos(p) && (b != rlepsd_pkg::magic_byte(p))) begin
            mm = 1'b1;
          end
          mismatch_d = mm;
          if (p >= 4'd4 && p < 4'd8) begin
            unique case (p[1:0])
              2'd0:    size_d[7:0]   = size_q[7:0]   | b;
              2'd1:    size_d[15:8]  = size_q[15:8]  | b;
              2'd2:    size_d[23:16] = size_q[23:16] | b;
              default: size_d[31:24] = size_q[31:24] | b;
            endcase
          end
          if (p == 4'(rlepsd_pkg::HdrLen - 1)) begin
            push_valid_o = 1'b1;
            pos_d        = '0;
            if (mm) begin
              push_data_o.kind = rlepsd_pkg::KIND_HDR_BAD;
              phase_d          = PH_IGNORE;
            end else begin
              push_data_o.kind = rlepsd_pkg::KIND_HDR_OK;
              push_data_o.size = size_q;
              phase_d          = PH_BODY;
            end
          end else begin
            pos_d = p + 4'd1;
            if (last) begin
              push_valid_o     = 1'b1;
              push_data_o.kind = rlepsd_pkg::KIND_HDR_BAD;
            end
          end
        end
        PH_IGNORE: begin
          // drop everything up to the end of the file
        end
        PH_BODY: begin
          if ((b & rlepsd_pkg::CmdSingleMask) != 8'h00) begin
            push_valid_o      = 1'b1;
            push_data_o.count = 8'd1;
            push_data_o.pix   = (((b & rlepsd_pkg::AlphaMask) != 8'h00)
                                 ? rlepsd_pkg::AlphaFill : 8'h00)
                                | (b & rlepsd_pkg::ColourMask);
          end else begin
            run_len_d = b[6:0];
            phase_d   = PH_LITERAL;
            if (last) begin
              push_valid_o     = 1'b1;
              push_data_o.kind = rlepsd_pkg::KIND_TRUNC;
            end
          end
        end
        PH_LITERAL: begin
          push_valid_o      = 1'b1;
          push_data_o.pix   = b;
          push_data_o.count = {1'b0, run_len_q} + 8'(rlepsd_pkg::RunBias);
          run_len_d         = '0;
          phase_d           = PH_BODY;
        end
        default: phase_d = PH_HEADER;
      endcase

      if (last) begin
        phase_d    = PH_HEADER;
        pos_d      = '0;
        mismatch_d = 1'b0;
        size_d     = '0;
        run_len_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      mismatch_q <= 1'b0;
      size_q     <= '0;
      run_len_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      mismatch_q <= mismatch_d;
      size_q     <= size_d;
      run_len_q  <= run_len_d;
    end
  end

endmodule

>>> hdl/rlepsd_queue.sv
// Small register queue of decoder commands between front end and expander.
module rlepsd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  rlepsd_pkg::cmd_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output rlepsd_pkg::cmd_t pop_data_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rlepsd_pkg::cmd_t mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

>>> hdl/rlepsd_back.sv
// Back end: expands commands into result items of up to four pixels each, or status items.
module rlepsd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  rlepsd_pkg::cmd_t      pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rlepsd_pkg::out_item_t out_data_o
);

  logic                  busy_q;
  rlepsd_pkg::cmd_t      cur_q;
  logic [7:0]            rem_q;
  logic                  out_valid_q;
  rlepsd_pkg::out_item_t out_q;

  logic                  step, is_status, chunk_last, load;
  logic [2:0]            cnt;
  rlepsd_pkg::out_item_t res;

  assign step       = busy_q && (!out_valid_q || out_ready_i);
  assign is_status  = (cur_q.kind != rlepsd_pkg::KIND_PIXELS);
  assign chunk_last = is_status || (rem_q <= 8'(rlepsd_pkg::PixPerResult));
  assign load       = pop_valid_i && (!busy_q || (step && chunk_last));
  assign pop_ready_o = load;

  always_comb begin
    cnt = is_status ? 3'd0
        : (chunk_last ? rem_q[2:0] : 3'(rlepsd_pkg::PixPerResult));
    res.kind          = cur_q.kind;
    res.original_size = cur_q.size;
    res.pixel_one     = (cnt >= 3'd1) ? cur_q.pix : 8'h00;
    res.pixel_two     = (cnt >= 3'd2) ? cur_q.pix : 8'h00;
    res.pixel_three   = (cnt >= 3'd3) ? cur_q.pix : 8'h00;
    res.pixel_four    = (cnt >= 3'd4) ? cur_q.pix : 8'h00;
    res.pixel_count   = cnt;
    res.run_end       = chunk_last;
    res.stream_end    = chunk_last && cur_q.stream_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (step && chunk_last) begin
        busy_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_data_i;
      rem_q <= pop_data_i.count;
    end else if (step) begin
      // advance through the run
      rem_q <= rem_q - 8'(rlepsd_pkg::PixPerResult);
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_status_no_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != rlepsd_pkg::KIND_PIXELS)
    |-> (out_data_o.pixel_count == 3'd0) && out_data_o.run_end)
    else $error("status item carries pixels or lacks run end");

  a_pixel_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == rlepsd_pkg::KIND_PIXELS)
    |-> (out_data_o.pixel_count != 3'd0) && (out_data_o.pixel_count <= 3'd4))
    else $error("pixel item with bad count");

  a_stream_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stream_end |-> out_data_o.run_end)
    else $error("stream end without run end");

  a_no_load_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(step && chunk_last) |-> !pop_ready_o)
    else $error("command taken while a run is still expanding");

endmodule

>>> hdl/rle_pixel_stream_decoder.sv
// Top level of the run-length RGBA2222 pixel stream decoder.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one byte of the
//   compressed file per item, with last_byte set on the final byte. The first
//   14 bytes form the header; its verdict comes out as one status item.
//   Output channel (out_valid_o/out_ready_i/out_data_o) carries result items:
//   up to four pixels each, or a status (header ok, header bad or short,
//   truncated run).
//   A result passes through the command queue, the expander's command
//   register and the output register before it is valid at the output.
//   Throughput: one byte per cycle while bytes give at most one result and the
//   receiver keeps up; a long run occupies the expander until all its groups
//   of four pixels are out, which holds the input back once the queue is full.
//   Reset clears the header state, the queue and the output register; the
//   block then expects a header. A stalled receiver holds the output item,
//   then the expander, then the queue, and finally the input ready.
module rle_pixel_stream_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rlepsd_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rlepsd_pkg::out_item_t out_data_o
);

  logic             push_valid, push_ready;
  rlepsd_pkg::cmd_t push_data;
  logic             pop_valid, pop_ready;
  rlepsd_pkg::cmd_t pop_data;

  rlepsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rlepsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rlepsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the run-length RGBA2222 pixel stream decoder.
module tb;

  localparam int CycleLimit = 300000;
  localparam int SettleCycles = 8;
  localparam logic [3:0][7:0] TagHead = {"r", "p", "m", "C"};
  localparam logic [3:0][7:0] TagTail = {"2", "E", "L", "R"};

  typedef enum logic [1:0] {
    DEC_HEADER,
    DEC_BODY,
    DEC_IGNORE,
    DEC_LITERAL
  } dec_phase_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  rlepsd_pkg::in_item_t  in_data = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  rlepsd_pkg::out_item_t out_data_o;

  rle_pixel_stream_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decoder state as predicted
  dec_phase_e  dec_phase = DEC_HEADER;
  logic [3:0]  hdr_pos = '0;
  logic        hdr_bad = 1'b0;
  logic [31:0] size_acc = '0;
  logic [6:0]  run_len = '0;

  rlepsd_pkg::out_item_t decoded_q[$];
  int          owed = 0;
  int          errors = 0;
  int          cycle_n = 0;
  int          bytes_n = 0;
  int          files_n = 0;
  int          kind_n[4] = '{0, 0, 0, 0};

  rlepsd_pkg::in_item_t tx_item = '0;
  bit          tx_busy = 1'b0;
  bit          offering = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;

  logic [7:0]  file_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_n, what, got, want);
    errors++;
  endtask

  task automatic queue_result(input rlepsd_pkg::out_item_t r);
    decoded_q.push_back(r);
    owed++;
  endtask

  function automatic rlepsd_pkg::out_item_t make_status(input rlepsd_pkg::kind_e k,
                                                        input logic [31:0] sz,
                                                        input logic se);
    rlepsd_pkg::out_item_t r;
    r = '0;
    r.kind = k;
    r.original_size = sz;
    r.run_end = 1'b1;
    r.stream_end = se;
    return r;
  endfunction

  task automatic decode_byte(input rlepsd_pkg::in_item_t it);
    rlepsd_pkg::out_item_t r;
    int unsigned p;
    int unsigned left;
    int unsigned chunk;
    logic [7:0]  b;
    b = it.data_byte;
    case (dec_phase)
      DEC_HEADER: begin
        p = 32'(hdr_pos);
        if (p > rlepsd_pkg::HdrLen - 1) p = rlepsd_pkg::HdrLen - 1;
        if (p < 4) begin
          if (b != TagHead[p]) hdr_bad = 1'b1;
        end else if (p >= 8 && p < 12) begin
          if (b != TagTail[p - 8]) hdr_bad = 1'b1;
        end else if (p < 8) begin
          size_acc = size_acc | (32'(b) << (8 * (p - 4)));
        end
        if (p == rlepsd_pkg::HdrLen - 1) begin
          if (hdr_bad) begin
            queue_result(make_status(rlepsd_pkg::KIND_HDR_BAD, '0, it.last_byte));
            dec_phase = DEC_IGNORE;
          end else begin
            queue_result(make_status(rlepsd_pkg::KIND_HDR_OK, size_acc, it.last_byte));
            dec_phase = DEC_BODY;
          end
          hdr_pos = '0;
        end else begin
          hdr_pos = 4'(p + 1);
          if (it.last_byte) queue_result(make_status(rlepsd_pkg::KIND_HDR_BAD, '0, 1'b1));
        end
      end
      DEC_IGNORE: ;
      DEC_BODY: begin
        if ((b & rlepsd_pkg::CmdSingleMask) != 0) begin
          r = '0;
          r.kind = rlepsd_pkg::KIND_PIXELS;
          r.pixel_one = (((b & rlepsd_pkg::AlphaMask) != 0) ? rlepsd_pkg::AlphaFill : 8'h00)
                        | (b & rlepsd_pkg::ColourMask);
          r.pixel_count = 3'd1;
          r.run_end = 1'b1;
          r.stream_end = it.last_byte;
          queue_result(r);
        end else begin
          run_len = 7'(b & rlepsd_pkg::RunLenMask);
          dec_phase = DEC_LITERAL;
          if (it.last_byte) queue_result(make_status(rlepsd_pkg::KIND_TRUNC, '0, 1'b1));
        end
      end
      DEC_LITERAL: begin
        left = 32'(run_len) + rlepsd_pkg::RunBias;
        while (left > 0) begin
          chunk = (left > rlepsd_pkg::PixPerResult) ? rlepsd_pkg::PixPerResult : left;
          left -= chunk;
          r = '0;
          r.kind = rlepsd_pkg::KIND_PIXELS;
          r.pixel_one = b;
          r.pixel_two = (chunk >= 2) ? b : 8'h00;
          r.pixel_three = (chunk >= 3) ? b : 8'h00;
          r.pixel_four = (chunk >= 4) ? b : 8'h00;
          r.pixel_count = 3'(chunk);
          r.run_end = (left == 0);
          r.stream_end = (left == 0) && it.last_byte;
          queue_result(r);
        end
        run_len = '0;
        dec_phase = DEC_BODY;
      end
    endcase
    // End of file: back to expecting a header
    if (it.last_byte) begin
      dec_phase = DEC_HEADER;
      hdr_pos = '0;
      hdr_bad = 1'b0;
      size_acc = '0;
      run_len = '0;
    end
  endtask

  task automatic check_result(input rlepsd_pkg::out_item_t got);
    rlepsd_pkg::out_item_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("result with none expected, kind", 32'(got.kind), '0);
      return;
    end
    want = decoded_q.pop_front();
    owed--;
    kind_n[want.kind]++;
    if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.original_size !== want.original_size)
      report_mismatch("original_size", got.original_size, want.original_size);
    if (got.pixel_one !== want.pixel_one)
      report_mismatch("pixel_one", 32'(got.pixel_one), 32'(want.pixel_one));
    if (got.pixel_two !== want.pixel_two)
      report_mismatch("pixel_two", 32'(got.pixel_two), 32'(want.pixel_two));
    if (got.pixel_three !== want.pixel_three)
      report_mismatch("pixel_three", 32'(got.pixel_three), 32'(want.pixel_three));
    if (got.pixel_four !== want.pixel_four)
      report_mismatch("pixel_four", 32'(got.pixel_four), 32'(want.pixel_four));
    if (got.pixel_count !== want.pixel_count)
      report_mismatch("pixel_count", 32'(got.pixel_count), 32'(want.pixel_count));
    if (got.run_end !== want.run_end)
      report_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
    if (got.stream_end !== want.stream_end)
      report_mismatch("stream_end", 32'(got.stream_end), 32'(want.stream_end));
  endtask

  // Sample both channels at the rising edge; predict before checking
  always @(posedge clk_i) begin
    cycle_n++;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        decode_byte(in_data);
        bytes_n++;
        offering = 1'b0;
        tx_busy = 1'b0;
      end
      if (out_valid_o && out_ready) check_result(out_data_o);
    end
  end

  // Sender: hold an offered item until it is taken
  always @(negedge clk_i) begin
    if (offering) begin
      in_valid <= 1'b1;
    end else if (tx_busy && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= tx_item;
      offering = 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (cycle_n >= CycleLimit);
    $display("timeout after %0d cycles with %0d results outstanding", cycle_n, owed);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    tx_item.data_byte = b;
    tx_item.last_byte = last;
    tx_busy = 1'b1;
    wait (!tx_busy);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_n++;
    file_q.delete();
  endtask

  task automatic wait_drained();
    wait (owed == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [6:0] rand_run_len();
    // Mostly short runs, now and then a long one
    return ($urandom_range(99) < 75) ? 7'($urandom_range(6)) : 7'($urandom_range(127));
  endfunction

  task automatic put_header(input bit good, input logic [31:0] sz);
    int bad_at;
    bad_at = $urandom_range(7);
    if (bad_at >= 4) bad_at += 4;
    for (int i = 0; i < 4; i++) file_q.push_back(TagHead[i]);
    for (int i = 0; i < 4; i++) file_q.push_back(sz[8*i +: 8]);
    for (int i = 0; i < 4; i++) file_q.push_back(TagTail[i]);
    file_q.push_back(8'($urandom));
    file_q.push_back(8'($urandom));
    if (!good) file_q[bad_at] = file_q[bad_at] ^ (8'h01 << $urandom_range(7));
  endtask

  task automatic put_run(input logic [6:0] len, input logic [7:0] lit);
    file_q.push_back({1'b0, len});
    file_q.push_back(lit);
  endtask

  task automatic put_random_body(input int n);
    repeat (n) begin
      if ($urandom_range(1) == 0) file_q.push_back(8'h80 | 8'($urandom_range(127)));
      else put_run(rand_run_len(), 8'($urandom));
    end
  endtask

  // Singles at the alpha and colour extremes, runs of every chunk shape, truncation
  task automatic test_directed_body();
    put_header(1'b1, 32'hFFFF_FFFF);
    file_q.push_back(8'h80);
    file_q.push_back(8'hFF);
    file_q.push_back(8'hC0);
    file_q.push_back(8'hBF);
    put_run(7'd0, 8'hFF);
    put_run(7'd1, 8'h00);
    put_run(7'd2, 8'hA5);
    put_run(7'h7F, 8'h5A);
    file_q.push_back(8'h05);
    send_file();
    wait_drained();
  endtask

  // Short file, rejected header with ignored tail, empty body
  task automatic test_header_cases();
    file_q.push_back("C");
    send_file();
    put_header(1'b0, $urandom);
    file_q.push_back(8'h81);
    file_q.push_back(8'h00);
    send_file();
    put_header(1'b1, 32'h0000_0000);
    send_file();
    wait_drained();
  endtask

  task automatic test_random(input int target);
    int done_n;
    int pick;
    int n;
    done_n = 0;
    while (done_n < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        n = $urandom_range(1, 20);
        repeat (n) file_q.push_back(8'($urandom));
        done_n += n;
      end else if (pick < 14) begin
        put_header(1'b0, $urandom);
        repeat ($urandom_range(4)) file_q.push_back(8'($urandom));
        done_n += file_q.size();
      end else if (pick < 20) begin
        put_header(1'b1, $urandom);
        n = $urandom_range(1, rlepsd_pkg::HdrLen - 1);
        while (file_q.size() > n) void'(file_q.pop_back());
        done_n += n;
      end else begin
        put_header(1'b1, ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom);
        put_random_body($urandom_range(12));
        if ($urandom_range(9) == 0) file_q.push_back({1'b0, rand_run_len()});
        done_n += file_q.size();
      end
      send_file();
    end
    wait_drained();
  endtask

  // Hold the receiver off while long runs keep coming, so the input stalls
  task automatic test_backpressure();
    put_header(1'b1, $urandom);
    repeat (5) begin
      put_run(7'h7F, 8'($urandom));
      file_q.push_back(8'h80 | 8'($urandom_range(127)));
    end
    hold_left = 400;
    send_file();
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 82;
    test_directed_body();
    test_header_cases();
    test_random(45);

    send_idle_pct = 82;
    recv_idle_pct = 31;
    test_random(45);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(50);

    if (decoded_q.size() != 0)
      report_mismatch("results never delivered", 32'(decoded_q.size()), '0);
    $display("sent %0d files, %0d bytes; checked %0d pixel, %0d header ok, %0d header bad",
             files_n, bytes_n, kind_n[rlepsd_pkg::KIND_PIXELS],
             kind_n[rlepsd_pkg::KIND_HDR_OK], kind_n[rlepsd_pkg::KIND_HDR_BAD]);
    $display("and %0d truncated-run results, with three idling mixes and a long output hold",
             kind_n[rlepsd_pkg::KIND_TRUNC]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> rle_pixel_stream_decoder.f
hdl/rlepsd_pkg.sv
hdl/rlepsd_front.sv
hdl/rlepsd_queue.sv
hdl/rlepsd_back.sv
hdl/rle_pixel_stream_decoder.sv
verif/tb.sv
